// ===== design/pixel_replicate_upscaler_top_defines.svh =====
// Assertion macros for the pixel replicate upscaler.
// Included by pixel_replicate_upscaler_top.sv; expects aclk and aresetn in scope.
`ifndef PIXEL_REPLICATE_UPSCALER_TOP_DEFINES_SVH
`define PIXEL_REPLICATE_UPSCALER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define PRU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define PRU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pru_pkg.sv =====
// Package for the pixel replicate upscaler: word types, codes and constants.
// No dependencies; imported by pixel_replicate_upscaler_top.
`timescale 1ns / 1ps

package pru_pkg;

    // Sizes of the register fields
    localparam int PRU_MAX_WIDTH  = 1024;
    localparam int SCALE_W        = 7;
    localparam int IN_WIDTH_W     = 11;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 11;
    localparam int SCALE_MAX      = 100;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IN_WIDTH = 2'd1;

    // Commands
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_PUSH_OK   = 2'd0;
    localparam logic [1:0] ST_PUSH_BUSY = 2'd1;
    localparam logic [1:0] ST_PIXEL     = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic       command;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic [1:0] pad_bytes;
        logic       row_last;
    } out_word_t;

endpackage

// ===== design/pixel_replicate_upscaler_top.sv =====
// Pixel replicate upscaler: line store, replay counters and result register.
// Depends on pru_pkg and pixel_replicate_upscaler_top_defines.svh.
//
// A result word is registered: it becomes valid in the cycle after its input word is accepted.
// Throughput: one input word per cycle while results are taken; the line store is read once per pull.
// Reset (aresetn low, synchronous) clears counters, flags and m_valid and sets
// scale 1, in_width 1; the line store keeps no reset and needs no clear pass.
`timescale 1ns / 1ps

`include "pixel_replicate_upscaler_top_defines.svh"

module pixel_replicate_upscaler_top
    import pru_pkg::*;
#(
    parameter int MAX_WIDTH = PRU_MAX_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input words
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_word_t               s_data,
    // result words
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_word_t              m_data
);

    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
    localparam int WW     = (CNT_W > IN_WIDTH_W) ? CNT_W : IN_WIDTH_W;
    localparam int CW     = WW + 1;

    // Configuration registers
    logic [SCALE_W-1:0]    scale_reg;
    logic [IN_WIDTH_W-1:0] in_width_reg;

    // Control state
    logic [ADDR_W-1:0]  fill_count_reg, fill_count_next;
    logic               row_ready_reg, row_ready_next;
    logic [ADDR_W-1:0]  out_column_reg, out_column_next;
    logic [SCALE_W-1:0] copy_count_reg, copy_count_next;
    logic [SCALE_W-1:0] row_repeat_reg, row_repeat_next;

    // Result register
    logic       m_valid_reg;
    logic [1:0] status_reg, status_next;
    logic [1:0] pad_reg, pad_next;
    logic       last_reg, last_next;
    logic [23:0] rd_data_reg;

    // Line store
    logic [23:0] line_mem [MAX_WIDTH];

    logic               s_accept;
    logic               push_write;
    logic [WW-1:0]      w_eff;
    logic [WW-1:0]      w_ext;
    logic [SCALE_W-1:0] s_eff;
    logic               col_done;
    logic               row_end;
    logic               rep_done;
    logic [3:0]         pad_prod;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg    <= SCALE_W'(1);
            in_width_reg <= IN_WIDTH_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SCALE:    scale_reg    <= cfg_data[SCALE_W-1:0];
                REG_IN_WIDTH: in_width_reg <= cfg_data[IN_WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamped scale and width
    always_comb begin
        w_ext = WW'(in_width_reg);
        if (in_width_reg == '0) begin
            w_eff = WW'(1);
        end else if (w_ext > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        if (scale_reg == '0) begin
            s_eff = SCALE_W'(1);
        end else if (scale_reg > SCALE_W'(SCALE_MAX)) begin
            s_eff = SCALE_W'(SCALE_MAX);
        end else begin
            s_eff = scale_reg;
        end
    end

    // Span ends of the replay counters
    assign col_done = ({1'b0, copy_count_reg} + (SCALE_W+1)'(1)) >= {1'b0, s_eff};
    assign row_end  = col_done && ((CW'(out_column_reg) + CW'(1)) >= CW'(w_eff));
    assign rep_done = ({1'b0, row_repeat_reg} + (SCALE_W+1)'(1)) >= {1'b0, s_eff};

    // Row of w*s 3-byte pixels needs (w*s) mod 4 zero bytes to reach a word boundary
    assign pad_prod = {2'b00, w_eff[1:0]} * {2'b00, s_eff[1:0]};

    assign push_write = s_accept && (s_data.command == CMD_PUSH) && !row_ready_reg;

    // Next state and result fields for the accepted word
    always_comb begin
        fill_count_next = fill_count_reg;
        row_ready_next  = row_ready_reg;
        out_column_next = out_column_reg;
        copy_count_next = copy_count_reg;
        row_repeat_next = row_repeat_reg;
        status_next     = ST_EMPTY;
        pad_next        = 2'd0;
        last_next       = 1'b0;
        if (s_data.command == CMD_PUSH) begin
            if (row_ready_reg) begin
                status_next = ST_PUSH_BUSY;
            end else begin
                status_next = ST_PUSH_OK;
                if ((CW'(fill_count_reg) + CW'(1)) >= CW'(w_eff)) begin
                    row_ready_next  = 1'b1;
                    out_column_next = '0;
                    copy_count_next = '0;
                    row_repeat_next = '0;
                end else begin
                    fill_count_next = fill_count_reg + ADDR_W'(1);
                end
            end
        end else if (row_ready_reg) begin
            status_next = ST_PIXEL;
            if (!col_done) begin
                copy_count_next = copy_count_reg + SCALE_W'(1);
            end else if (!row_end) begin
                copy_count_next = '0;
                out_column_next = out_column_reg + ADDR_W'(1);
            end else begin
                pad_next        = pad_prod[1:0];
                last_next       = 1'b1;
                copy_count_next = '0;
                out_column_next = '0;
                if (rep_done) begin
                    row_repeat_next = '0;
                    row_ready_next  = 1'b0;
                    fill_count_next = '0;
                end else begin
                    row_repeat_next = row_repeat_reg + SCALE_W'(1);
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg <= '0;
            row_ready_reg  <= 1'b0;
            out_column_reg <= '0;
            copy_count_reg <= '0;
            row_repeat_reg <= '0;
        end else if (s_accept) begin
            fill_count_reg <= fill_count_next;
            row_ready_reg  <= row_ready_next;
            out_column_reg <= out_column_next;
            copy_count_reg <= copy_count_next;
            row_repeat_reg <= row_repeat_next;
        end
    end

    // Line store: write on push, registered read on pull
    always_ff @(posedge aclk) begin
        if (push_write) begin
            line_mem[fill_count_reg] <= {s_data.red, s_data.green, s_data.blue};
        end
        if (s_accept && (s_data.command == CMD_PULL)) begin
            rd_data_reg <= line_mem[out_column_reg];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            status_reg <= status_next;
            pad_reg    <= pad_next;
            last_reg   <= last_next;
        end
    end

    // Pixel bytes only on pixel words
    assign m_valid            = m_valid_reg;
    assign m_data.status      = status_reg;
    assign m_data.out_blue    = (status_reg == ST_PIXEL) ? rd_data_reg[7:0]   : 8'd0;
    assign m_data.out_green   = (status_reg == ST_PIXEL) ? rd_data_reg[15:8]  : 8'd0;
    assign m_data.out_red     = (status_reg == ST_PIXEL) ? rd_data_reg[23:16] : 8'd0;
    assign m_data.pad_bytes   = pad_reg;
    assign m_data.row_last    = last_reg;

    // Checks
    `PRU_ASSERT_NEXT(a_pull_empty, s_accept && (s_data.command == CMD_PULL) && !row_ready_reg, m_valid && (m_data.status == ST_EMPTY), "pull without a ready row must report empty")
    `PRU_ASSERT_NEXT(a_push_busy, s_accept && (s_data.command == CMD_PUSH) && row_ready_reg, m_valid && (m_data.status == ST_PUSH_BUSY) && row_ready_reg, "push during replay must be rejected")
    `PRU_ASSERT_NOW(a_last_is_pixel, m_valid && m_data.row_last, m_data.status == ST_PIXEL, "row end flagged on a non-pixel word")
    `PRU_ASSERT_NOW(a_pad_at_end, m_valid && (m_data.pad_bytes != 2'd0), m_data.row_last, "padding reported before row end")

endmodule
